### rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame stepper: payload structs,
// function codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Duration table depth and advance cap per tick.
  localparam int unsigned FRAME_DEPTH  = 256;
  localparam int unsigned MAX_ADVANCES = 16;

  localparam int unsigned TblAw = $clog2(FRAME_DEPTH);
  localparam int unsigned CntW  = $clog2(MAX_ADVANCES + 1);

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Input function codes.
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_WRITE   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_STEP     = 3'd0,
    CFG_FRAME_TOTAL    = 3'd1,
    CFG_LOOP_START     = 3'd2,
    CFG_MODEL_MODE     = 3'd3,
    CFG_FIXED_DURATION = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [15:0] duration_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  frame_index;
    logic [31:0] timer_value;
    logic [4:0]  advance_count;
    logic        wrapped;
    logic        stalled;
  } out_item_t;

endpackage

### rtl/core/sprite_frame_stepper.sv
// ----------------------------------------------------------------------------
// sprite_frame_stepper
// Animation frame sequencer: adds a speed to a timer on each tick and steps
// through frames while the timer exceeds the current frame's duration.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | in        | in_valid/in_stall  | sfs_pkg::in_item_t
//  out     | out       | out_valid/out_stall| sfs_pkg::out_item_t
//  cfg     | in        | cfg_valid/cfg_ready| register index, write data
//
// One item at a time. A tick runs the saturating add in S_ADD, then one S_STEP
// per advance in model mode or S_STEP and S_LOAD in sprite mode (S_LOAD waits
// on the registered duration table read), plus a final compare in S_STEP; at
// most MAX_ADVANCES advances. A table write or no-op beat is ready the cycle
// after acceptance, a restart after S_RLOAD. The result is held until taken
// and the next beat can be accepted the cycle after. Reset clears the control
// state and the configuration; the duration table is not cleared.

module sprite_frame_stepper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sfs_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sfs_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sfs_pkg::CfgDataW-1:0]    cfg_data_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_STEP  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_RLOAD = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] speed_q;
  logic [8:0]  total_q;
  logic [7:0]  loop_q;
  logic        model_q;
  logic [15:0] fixed_q;

  logic [31:0] elapsed_q, elapsed_d;
  logic [7:0]  frame_q, frame_d;
  logic [15:0] dur_now_q, dur_now_d;
  logic [sfs_pkg::CntW-1:0] cnt_q, cnt_d;
  logic        wrapped_q, wrapped_d;

  logic [15:0] tbl_q [sfs_pkg::FRAME_DEPTH];
  logic [15:0] rd_q;
  logic        rd_oob_q;

  logic        accept;
  logic        rd_en;
  logic [7:0]  rd_idx;
  logic        wr_en;
  logic [15:0] dur;
  logic [31:0] opb;
  logic        cin;
  logic [32:0] alu;
  logic        gt;
  logic        below_cap;
  logic [8:0]  nxt;
  logic        wrap;
  logic [15:0] rd_dur;

  function automatic logic in_range(input logic [7:0] idx);
    in_range = 32'(idx) < 32'(sfs_pkg::FRAME_DEPTH);
  endfunction

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cfg_ready_o = 1'b1;

  // Shared 32-bit adder: saturating add of the speed, or compare-and-subtract
  // of the current duration.
  assign dur = model_q ? fixed_q : dur_now_q;
  always_comb begin
    if (state_q == S_ADD) begin
      opb = {16'b0, speed_q};
      cin = 1'b0;
    end else begin
      opb = ~{16'b0, dur};
      cin = 1'b1;
    end
    alu = {1'b0, elapsed_q} + {1'b0, opb} + {32'b0, cin};
  end

  // Carry out of the subtraction means no borrow; a nonzero difference then
  // means the timer strictly exceeds the duration.
  assign gt        = alu[32] && (alu[31:0] != 32'b0);
  assign below_cap = cnt_q < sfs_pkg::CntW'(sfs_pkg::MAX_ADVANCES);
  assign nxt       = {1'b0, frame_q} + 9'd1;
  assign wrap      = (nxt >= total_q) || (nxt > 9'd255);
  assign rd_dur    = rd_oob_q ? 16'b0 : rd_q;

  assign wr_en = accept && (in_data_i.func == sfs_pkg::FUNC_WRITE) &&
                 in_range(in_data_i.entry_index);

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    frame_d   = frame_q;
    dur_now_d = dur_now_q;
    cnt_d     = cnt_q;
    wrapped_d = wrapped_q;
    rd_en     = 1'b0;
    rd_idx    = in_data_i.entry_index;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d     = '0;
          wrapped_d = 1'b0;
          case (in_data_i.func)
            sfs_pkg::FUNC_TICK: begin
              state_d = S_ADD;
            end
            sfs_pkg::FUNC_RESTART: begin
              frame_d   = in_data_i.entry_index;
              elapsed_d = 32'b0;
              rd_en     = 1'b1;
              state_d   = S_RLOAD;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_ADD: begin
        elapsed_d = alu[32] ? 32'hFFFF_FFFF : alu[31:0];
        state_d   = S_STEP;
      end
      S_STEP: begin
        if (gt && below_cap) begin
          elapsed_d = alu[31:0];
          frame_d   = wrap ? loop_q : nxt[7:0];
          cnt_d     = cnt_q + sfs_pkg::CntW'(1);
          if (wrap) begin
            wrapped_d = 1'b1;
          end
          if (!model_q) begin
            rd_en   = 1'b1;
            rd_idx  = frame_d;
            state_d = S_LOAD;
          end
        end else begin
          state_d = S_OUT;
        end
      end
      S_LOAD: begin
        dur_now_d = rd_dur;
        state_d   = S_STEP;
      end
      S_RLOAD: begin
        dur_now_d = rd_dur;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      elapsed_q <= 32'b0;
      frame_q   <= 8'b0;
      dur_now_q <= 16'b0;
      cnt_q     <= '0;
      wrapped_q <= 1'b0;
      speed_q   <= 16'b0;
      total_q   <= 9'd1;
      loop_q    <= 8'b0;
      model_q   <= 1'b0;
      fixed_q   <= 16'b0;
    end else begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      frame_q   <= frame_d;
      dur_now_q <= dur_now_d;
      cnt_q     <= cnt_d;
      wrapped_q <= wrapped_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sfs_pkg::CFG_SPEED_STEP:     speed_q <= cfg_data_i;
          sfs_pkg::CFG_FRAME_TOTAL:    total_q <= cfg_data_i[8:0];
          sfs_pkg::CFG_LOOP_START:     loop_q  <= cfg_data_i[7:0];
          sfs_pkg::CFG_MODEL_MODE:     model_q <= cfg_data_i[0];
          sfs_pkg::CFG_FIXED_DURATION: fixed_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Duration table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[sfs_pkg::TblAw'(in_data_i.entry_index)] <= in_data_i.duration_value;
    end
    if (rd_en) begin
      rd_q     <= tbl_q[sfs_pkg::TblAw'(rd_idx)];
      rd_oob_q <= !in_range(rd_idx);
    end
  end

  always_comb begin
    out_data_o.frame_index   = frame_q;
    out_data_o.timer_value   = elapsed_q;
    out_data_o.advance_count = (32'(cnt_q) > 32'd31) ? 5'd31 : 5'(cnt_q);
    out_data_o.wrapped       = wrapped_q;
    out_data_o.stalled       = cnt_q >= sfs_pkg::CntW'(sfs_pkg::MAX_ADVANCES);
  end

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a beat");

  a_cap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sfs_pkg::CntW'(sfs_pkg::MAX_ADVANCES))
    else $error("advance count beyond cap");

  a_stall_has_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.stalled) |-> (out_data_o.advance_count != 5'd0))
    else $error("stalled flag without advances");
`endif

endmodule
